/* hw/rtl/ifs_pkg.sv */
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared types and constants of the chaos-game point generator.
// ----------------------------------------------------------------------------
package ifs_pkg;

  localparam int COEF_BITS = 24;
  localparam int MAP_BITS  = 4;
  localparam int K_BITS    = 3;
  localparam int MODE_BITS = 2;
  localparam int CNT_BITS  = 4;
  localparam int COEFS     = 6;

  localparam logic [MODE_BITS-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_STEP    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_RESTART = 2'd2;

  localparam logic [K_BITS-1:0] K_A = 3'd0;
  localparam logic [K_BITS-1:0] K_B = 3'd1;
  localparam logic [K_BITS-1:0] K_C = 3'd2;
  localparam logic [K_BITS-1:0] K_D = 3'd3;
  localparam logic [K_BITS-1:0] K_E = 3'd4;
  localparam logic [K_BITS-1:0] K_F = 3'd5;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_STEP,
    OP_RESTART
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [MAP_BITS-1:0] map;
    logic [K_BITS-1:0]   k;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_WR,
    S_LD_RD,
    S_LD_UPD,
    S_SUM,
    S_THR,
    S_SCAN,
    S_AF,
    S_EMIT
  } st_t;

endpackage

/* hw/rtl/ifs_in_if.sv */
// ----------------------------------------------------------------------------
// ifs_in_if
// Request channel: coefficient loads, step and restart requests.
// ----------------------------------------------------------------------------
interface ifs_in_if #(
  parameter int RANDOM_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic [ifs_pkg::MODE_BITS-1:0]       mode;
  logic [ifs_pkg::MAP_BITS-1:0]        map_index;
  logic [ifs_pkg::K_BITS-1:0]          coef_index;
  logic signed [ifs_pkg::COEF_BITS-1:0] coef_value;
  logic [RANDOM_BITS-1:0]              random_fraction;

  modport source (output valid, mode, map_index, coef_index, coef_value, random_fraction,
                  input ready);
  modport sink   (input valid, mode, map_index, coef_index, coef_value, random_fraction,
                  output ready);
endinterface

/* hw/rtl/ifs_out_if.sv */
// ----------------------------------------------------------------------------
// ifs_out_if
// Result channel: new point and status flags.
// ----------------------------------------------------------------------------
interface ifs_out_if #(
  parameter int COORD_BITS = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_BITS-1:0]   point_x;
  logic signed [COORD_BITS-1:0]   point_y;
  logic [ifs_pkg::MAP_BITS-1:0]   chosen_map;
  logic                           not_convergent;
  logic                           saturated;

  modport source (output valid, point_x, point_y, chosen_map, not_convergent, saturated,
                  input ready);
  modport sink   (input valid, point_x, point_y, chosen_map, not_convergent, saturated,
                  output ready);
endinterface

/* hw/rtl/ifs_ram.sv */
// ----------------------------------------------------------------------------
// ifs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ifs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* hw/rtl/ifs_front.sv */
// ----------------------------------------------------------------------------
// ifs_front
// Accepts requests, drops the meaningless ones and queues the rest.
// ----------------------------------------------------------------------------
module ifs_front #(
  parameter int MAX_MAPS    = 10,
  parameter int RANDOM_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  ifs_in_if.sink                                in_ch,
  output logic                                  q_valid,
  input  logic                                  q_ready,
  output ifs_pkg::cmd_t                         q_cmd,
  output logic signed [ifs_pkg::COEF_BITS-1:0]  q_value,
  output logic [RANDOM_BITS-1:0]                q_rnd
);
  ifs_pkg::cmd_t                        cmd_r [2];
  logic signed [ifs_pkg::COEF_BITS-1:0] val_r [2];
  logic [RANDOM_BITS-1:0]               rnd_r [2];
  logic                                 wr_ptr_r, rd_ptr_r;
  logic [1:0]                           cnt_r, cnt_nxt;
  logic                                 accept, keep, push, pop;
  ifs_pkg::cmd_t                        cmd_in;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;

  // classify the request
  always_comb begin
    cmd_in.map = in_ch.map_index;
    cmd_in.k   = in_ch.coef_index;
    cmd_in.op  = ifs_pkg::OP_LOAD;
    keep       = 1'b0;
    unique case (in_ch.mode)
      ifs_pkg::MODE_LOAD: begin
        cmd_in.op = ifs_pkg::OP_LOAD;
        keep = (32'(in_ch.map_index) < MAX_MAPS) &&
               (32'(in_ch.coef_index) < ifs_pkg::COEFS);
      end
      ifs_pkg::MODE_STEP: begin
        cmd_in.op = ifs_pkg::OP_STEP;
        keep = 1'b1;
      end
      ifs_pkg::MODE_RESTART: begin
        cmd_in.op = ifs_pkg::OP_RESTART;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push    = accept && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_cmd   = cmd_r[rd_ptr_r];
  assign q_value = val_r[rd_ptr_r];
  assign q_rnd   = rnd_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_r[wr_ptr_r] <= cmd_in;
      val_r[wr_ptr_r] <= in_ch.coef_value;
      rnd_r[wr_ptr_r] <= in_ch.random_fraction;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("queue overfilled");
  a_drop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.mode != ifs_pkg::MODE_LOAD && in_ch.mode != ifs_pkg::MODE_STEP &&
     in_ch.mode != ifs_pkg::MODE_RESTART) |-> !push)
    else $error("unused mode queued");
endmodule

/* hw/rtl/ifs_back.sv */
// ----------------------------------------------------------------------------
// ifs_back
// Executes queued requests: coefficient updates, map choice, affine step.
// ----------------------------------------------------------------------------
module ifs_back #(
  parameter int MAX_MAPS    = 10,
  parameter int COORD_BITS  = 24,
  parameter int FRAC_BITS   = 16,
  parameter int RANDOM_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [ifs_pkg::CNT_BITS-1:0]         map_count,
  input  logic                                 q_valid,
  output logic                                 q_ready,
  input  ifs_pkg::cmd_t                        q_cmd,
  input  logic signed [ifs_pkg::COEF_BITS-1:0] q_value,
  input  logic [RANDOM_BITS-1:0]               q_rnd,
  ifs_out_if.source                            out_ch
);
  localparam int CB    = ifs_pkg::COEF_BITS;
  localparam int IW    = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
  localparam int DEPTH = MAX_MAPS * ifs_pkg::COEFS;
  localparam int AW    = $clog2(DEPTH);
  localparam int OPB   = (COORD_BITS > CB) ? COORD_BITS : CB;
  localparam int PW    = CB + OPB;
  localparam int WB    = 2 * CB;
  localparam int TB    = WB + ifs_pkg::MAP_BITS;
  localparam int SW    = PW + 1;
  localparam int RW    = SW + 1;
  localparam int NW    = IW + 1;
  localparam logic signed [CB-1:0] HALF  = CB'(1 << (FRAC_BITS - 1));
  localparam logic signed [CB-1:0] OFF1X = CB'((128 * (1 << FRAC_BITS) + 50) / 100);
  localparam logic signed [CB-1:0] OFF2X = CB'((64 * (1 << FRAC_BITS) + 50) / 100);
  localparam logic signed [CB-1:0] OFF2Y = CB'((8 * (1 << FRAC_BITS) + 5) / 10);
  localparam logic [WB-1:0]        DET0  = WB'(64'(1) << (2 * FRAC_BITS - 2));
  localparam logic signed [CB:0]   ONE   = (CB+1)'(1 << FRAC_BITS);
  localparam logic signed [COORD_BITS-1:0] START_X =
    COORD_BITS'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic signed [COORD_BITS-1:0] START_Y =
    -COORD_BITS'(((1 << (FRAC_BITS + 1)) + 5) / 10);
  localparam logic signed [RW-1:0] HI = RW'((64'(1) << (COORD_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] LO = -HI - RW'(1);

  ifs_pkg::st_t                 st_r, st_nxt;
  ifs_pkg::cmd_t                cmd_r;
  logic signed [CB-1:0]         val_r;
  logic [RANDOM_BITS-1:0]       rnd_r;
  logic [2:0]                   c_r;
  logic [IW-1:0]                idx_r, pick_r;
  logic [TB-1:0]                tot_r, run_r, run_n;
  logic [TB+RANDOM_BITS-1:0]    thr_r;
  logic [WB-1:0]                weight_r [MAX_MAPS];
  logic [MAX_MAPS-1:0]          trace_r, in_use;
  logic signed [CB-1:0]         ca_r, cb_r;
  logic                         trc_r;
  logic signed [PW-1:0]         p1_r, p2_r, mul_p;
  logic signed [CB-1:0]         mul_a;
  logic signed [OPB-1:0]        mul_b;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, nx_r;
  logic                         sat_r;
  logic                         out_valid_r, slot_free;

  // coefficient store
  logic [DEPTH-1:0]             vld_r;
  logic                         rd_en, rd_vld_r;
  logic [ifs_pkg::MAP_BITS-1:0] rd_map, rd_map_r;
  logic [ifs_pkg::K_BITS-1:0]   rd_k, rd_k_r;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic                         ram_we;
  logic [CB-1:0]                ram_q;
  logic signed [CB-1:0]         dflt, cdat;

  logic [NW-1:0]                n_use;
  logic [IW-1:0]                last;
  logic signed [SW-1:0]         af_sum;
  logic signed [RW-1:0]         af_r;
  logic signed [COORD_BITS-1:0] af_val;
  logic                         af_sat;
  logic signed [PW:0]           det;
  logic [WB-1:0]                det_abs;
  logic signed [CB:0]           tr;

  assign rd_addr = AW'(rd_map) * AW'(ifs_pkg::COEFS) + AW'(rd_k);
  assign wr_addr = AW'(cmd_r.map) * AW'(ifs_pkg::COEFS) + AW'(cmd_r.k);
  assign ram_we  = (st_r == ifs_pkg::S_LD_WR);

  ifs_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_coef (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (val_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // reset contents of an entry never written
  always_comb begin
    dflt = '0;
    if (rd_map_r < 4'd3) begin
      case (rd_k_r)
        ifs_pkg::K_A, ifs_pkg::K_D: dflt = HALF;
        ifs_pkg::K_E: dflt = (rd_map_r == 4'd1) ? OFF1X :
                             (rd_map_r == 4'd2) ? OFF2X : '0;
        ifs_pkg::K_F: dflt = (rd_map_r == 4'd2) ? OFF2Y : '0;
        default:      dflt = '0;
      endcase
    end
  end
  assign cdat = rd_vld_r ? $signed(ram_q) : dflt;

  // maps in use
  always_comb begin
    if (map_count == '0) begin
      n_use = NW'(1);
    end else if (32'(map_count) > MAX_MAPS) begin
      n_use = NW'(MAX_MAPS);
    end else begin
      n_use = NW'(map_count);
    end
    for (int i = 0; i < MAX_MAPS; i++) begin
      in_use[i] = (NW'(i) < n_use);
    end
  end
  assign last = IW'(n_use - NW'(1));

  // read order: load a,d,b,c; step a,b,e,c,d,f
  always_comb begin
    rd_en  = 1'b0;
    rd_map = cmd_r.map;
    rd_k   = ifs_pkg::K_A;
    if (st_r == ifs_pkg::S_LD_RD && c_r < 3'd4) begin
      rd_en = 1'b1;
      case (c_r)
        3'd0:    rd_k = ifs_pkg::K_A;
        3'd1:    rd_k = ifs_pkg::K_D;
        3'd2:    rd_k = ifs_pkg::K_B;
        default: rd_k = ifs_pkg::K_C;
      endcase
    end else if (st_r == ifs_pkg::S_AF && c_r < 3'd6) begin
      rd_en  = 1'b1;
      rd_map = ifs_pkg::MAP_BITS'(pick_r);
      case (c_r)
        3'd0:    rd_k = ifs_pkg::K_A;
        3'd1:    rd_k = ifs_pkg::K_B;
        3'd2:    rd_k = ifs_pkg::K_E;
        3'd3:    rd_k = ifs_pkg::K_C;
        3'd4:    rd_k = ifs_pkg::K_D;
        default: rd_k = ifs_pkg::K_F;
      endcase
    end
  end

  // shared multiplier
  always_comb begin
    if (st_r == ifs_pkg::S_LD_RD) begin
      mul_a = (c_r == 3'd2) ? ca_r : cb_r;
      mul_b = OPB'(cdat);
    end else begin
      mul_a = cdat;
      mul_b = (c_r == 3'd1 || c_r == 3'd4) ? OPB'(cur_x_r) : OPB'(cur_y_r);
    end
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // floor((p1+p2)/2^F) + offset, saturated
  always_comb begin
    af_sum = SW'(p1_r) + SW'(p2_r);
    af_r   = RW'(af_sum >>> FRAC_BITS) + RW'(cdat);
    af_sat = (af_r > HI) || (af_r < LO);
    if (af_r > HI) begin
      af_val = COORD_BITS'(HI);
    end else if (af_r < LO) begin
      af_val = COORD_BITS'(LO);
    end else begin
      af_val = COORD_BITS'(af_r);
    end
  end

  assign det     = (PW+1)'(p1_r) - (PW+1)'(p2_r);
  assign det_abs = det[PW] ? WB'(-det) : WB'(det);
  assign tr      = (CB+1)'(ca_r) + (CB+1)'(cdat);
  assign run_n   = run_r + TB'(weight_r[idx_r]);

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_ready   = (st_r == ifs_pkg::S_IDLE);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ifs_pkg::S_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            ifs_pkg::OP_LOAD:    st_nxt = ifs_pkg::S_LD_WR;
            ifs_pkg::OP_STEP:    st_nxt = ifs_pkg::S_SUM;
            ifs_pkg::OP_RESTART: st_nxt = ifs_pkg::S_EMIT;
            default:             st_nxt = ifs_pkg::S_IDLE;
          endcase
        end
      end
      ifs_pkg::S_LD_WR:  st_nxt = ifs_pkg::S_LD_RD;
      ifs_pkg::S_LD_RD:  if (c_r == 3'd4) st_nxt = ifs_pkg::S_LD_UPD;
      ifs_pkg::S_LD_UPD: st_nxt = ifs_pkg::S_IDLE;
      ifs_pkg::S_SUM:    if (idx_r == last) st_nxt = ifs_pkg::S_THR;
      ifs_pkg::S_THR:    st_nxt = (tot_r == '0) ? ifs_pkg::S_AF : ifs_pkg::S_SCAN;
      ifs_pkg::S_SCAN: begin
        if ((thr_r <= {run_n, {RANDOM_BITS{1'b0}}}) || idx_r == last) begin
          st_nxt = ifs_pkg::S_AF;
        end
      end
      ifs_pkg::S_AF:     if (c_r == 3'd6) st_nxt = ifs_pkg::S_EMIT;
      ifs_pkg::S_EMIT:   if (slot_free) st_nxt = ifs_pkg::S_IDLE;
      default:           st_nxt = ifs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ifs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      trace_r     <= '0;
      cur_x_r     <= START_X;
      cur_y_r     <= START_Y;
      for (int i = 0; i < MAX_MAPS; i++) begin
        weight_r[i] <= (i < 3) ? DET0 : '0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == ifs_pkg::S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ifs_pkg::S_IDLE: begin
          if (q_valid && q_cmd.op == ifs_pkg::OP_RESTART) begin
            cur_x_r <= START_X;
            cur_y_r <= START_Y;
          end
        end
        ifs_pkg::S_LD_WR: begin
          vld_r[wr_addr] <= 1'b1;
        end
        ifs_pkg::S_LD_UPD: begin
          weight_r[cmd_r.map[IW-1:0]] <= det_abs;
          trace_r[cmd_r.map[IW-1:0]]  <= trc_r;
        end
        ifs_pkg::S_AF: begin
          if (c_r == 3'd6) begin
            cur_x_r <= nx_r;
            cur_y_r <= af_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
      rd_map_r <= rd_map;
      rd_k_r   <= rd_k;
    end
    case (st_r)
      ifs_pkg::S_IDLE: begin
        cmd_r <= q_cmd;
        val_r <= q_value;
        rnd_r <= q_rnd;
        c_r   <= '0;
        idx_r <= '0;
        tot_r <= '0;
        run_r <= '0;
        sat_r <= 1'b0;
      end
      ifs_pkg::S_LD_RD: begin
        c_r <= c_r + 3'd1;
        if (c_r == 3'd1) ca_r <= cdat;
        if (c_r == 3'd3) cb_r <= cdat;
        if (c_r == 3'd2) begin
          p1_r  <= mul_p;
          trc_r <= (tr > ONE) || (tr < -ONE);
        end
        if (c_r == 3'd4) p2_r <= mul_p;
      end
      ifs_pkg::S_SUM: begin
        tot_r <= tot_r + TB'(weight_r[idx_r]);
        idx_r <= idx_r + IW'(1);
      end
      ifs_pkg::S_THR: begin
        thr_r  <= (TB+RANDOM_BITS)'(tot_r) * (TB+RANDOM_BITS)'(rnd_r);
        idx_r  <= '0;
        pick_r <= last;
      end
      ifs_pkg::S_SCAN: begin
        run_r  <= run_n;
        idx_r  <= idx_r + IW'(1);
        pick_r <= idx_r;
      end
      ifs_pkg::S_AF: begin
        c_r <= c_r + 3'd1;
        if (c_r == 3'd1 || c_r == 3'd4) p1_r <= mul_p;
        if (c_r == 3'd2 || c_r == 3'd5) p2_r <= mul_p;
        if (c_r == 3'd3) nx_r <= af_val;
        if (c_r == 3'd3 || c_r == 3'd6) sat_r <= sat_r | af_sat;
      end
      ifs_pkg::S_EMIT: begin
        if (slot_free) begin
          out_ch.point_x        <= cur_x_r;
          out_ch.point_y        <= cur_y_r;
          out_ch.chosen_map     <= (cmd_r.op == ifs_pkg::OP_RESTART) ?
                                   '0 : ifs_pkg::MAP_BITS'(pick_r);
          out_ch.not_convergent <= |(trace_r & in_use);
          out_ch.saturated      <= (cmd_r.op == ifs_pkg::OP_RESTART) ? 1'b0 : sat_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid = out_valid_r;

  a_pick_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ifs_pkg::S_AF) |-> (pick_r <= last))
    else $error("chosen map outside maps in use");
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ifs_pkg::S_EMIT && slot_free && cmd_r.op == ifs_pkg::OP_RESTART) |=>
    (out_ch.valid && out_ch.chosen_map == '0 && !out_ch.saturated))
    else $error("restart result not clean");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ifs_pkg::S_SCAN || st_r == ifs_pkg::S_SUM) |-> (idx_r <= last))
    else $error("weight walk ran past maps in use");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_ch.point_x)))
    else $error("pending result overwritten");
endmodule

/* hw/rtl/ifs_chaos_game_point_generator.sv */
// ----------------------------------------------------------------------------
// ifs_chaos_game_point_generator
// Chaos-game point generator for an iterated function system.
// ----------------------------------------------------------------------------
// Requests enter a two-deep queue and are executed one at a time by a sequencer
// around a coefficient RAM and one shared multiplier. A coefficient load writes
// the value, then makes four reads feeding two determinant products, then updates
// the map's weight. A step adds up the weights of the n maps in use (by default
// three), forms the threshold, walks the running weights to pick a map, makes the
// six coefficient reads and four multiplies, and hands over the result. A restart
// hands over the start point. Results sit in an output register, so the next
// request is queued while a result waits to be taken.
module ifs_chaos_game_point_generator #(
  parameter int MAX_MAPS    = 10,
  parameter int COORD_BITS  = 24,
  parameter int FRAC_BITS   = 16,
  parameter int RANDOM_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ifs_in_if.sink                       in_ch,
  ifs_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [ifs_pkg::CNT_BITS-1:0] cfg_data
);
  logic [ifs_pkg::CNT_BITS-1:0]         map_count_r;
  logic                                 q_valid, q_ready;
  ifs_pkg::cmd_t                        q_cmd;
  logic signed [ifs_pkg::COEF_BITS-1:0] q_value;
  logic [RANDOM_BITS-1:0]               q_rnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_count_r <= ifs_pkg::CNT_BITS'(3);
    end else if (cfg_we) begin
      map_count_r <= cfg_data;
    end
  end

  ifs_front #(.MAX_MAPS(MAX_MAPS), .RANDOM_BITS(RANDOM_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .q_value (q_value),
    .q_rnd   (q_rnd)
  );

  ifs_back #(
    .MAX_MAPS    (MAX_MAPS),
    .COORD_BITS  (COORD_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .map_count (map_count_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .q_value   (q_value),
    .q_rnd     (q_rnd),
    .out_ch    (out_ch)
  );
endmodule
